// ----- src/hdt_pkg.sv -----
`default_nettype none
package hdt_pkg;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAN  = 2'd2;

  localparam int KEY_W      = 64;
  localparam int SLOT_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int MAX_EVICT  = 64;
  localparam int DIGIT_W    = 4;
  localparam int HASH_STEPS = KEY_W / DIGIT_W;
  localparam int HCNT_W     = $clog2(HASH_STEPS);

  localparam logic [4:0]  BUCKET_COUNT_RST = 5'd16;
  localparam logic [31:0] AGE_LIMIT_RST    = 32'd60000;

  localparam logic REG_BUCKET_COUNT = 1'b0;
  localparam logic REG_AGE_LIMIT    = 1'b1;

  typedef enum logic [2:0] {
    R_LOOKUP,
    R_INS_OK,
    R_FULL,
    R_EVICT,
    R_FINAL,
    R_NULL
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      hash_step;
    logic      lk_next;
    logic      ins_setup;
    logic      ins_shift;
    logic      ins_head;
    logic      cl_next_bkt;
    logic      cl_evict;
    logic      cl_keep;
    logic      clr_step;
    logic      emit;
    res_kind_t kind;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic [1:0] cmd;
    logic       hash_done;
    logic       rd_ge_fill;
    logic       key_match;
    logic       fill_full;
    logic       fill_zero;
    logic       rd_zero;
    logic       evict;
    logic       pend_v;
    logic       last_bkt;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- src/hdt_datapath.sv -----
`default_nettype none
module hdt_datapath
  import hdt_pkg::*;
#(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS        = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic         wr_index,
  input  wire logic [31:0]  wr_data,
  input  wire logic [1:0]   s_tuser,
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [79:0]       m_tdata,
  output logic [2:0]        m_tuser,
  output logic              m_tlast,
  input  wire ctrl_t        ctrl,
  output stat_t             stat
);

  localparam int DEPTH = NUM_BUCKETS * WAYS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int FW = $clog2(WAYS + 1);

  logic [4:0]  bucket_count;
  logic [31:0] age_limit;

  logic [1:0]  cmd_r;
  logic [63:0] key_r, stamp_r, hsh;
  logic [4:0]  rem;
  logic [HCNT_W-1:0] hcnt;
  logic [BW-1:0] bkt;
  logic [FW-1:0] rd, wr, fill_q;
  logic [COUNT_W-1:0] cnt;
  logic [63:0] pend_key;
  logic        pend_v;

  logic [63:0] key_mem  [DEPTH];
  logic [63:0] time_mem [DEPTH];
  logic [FW-1:0] fill_mem [NUM_BUCKETS];
  logic [63:0] key_q, time_q;

  logic [4:0] n_eff;
  logic [4:0] rem_next;
  logic [5:0] r6;
  logic [FW-1:0] rd_pos, wpos;
  logic [AW-1:0] rd_addr, wr_addr;
  logic       ent_we, fill_we;
  logic [63:0] wkey, wtime;
  logic [FW-1:0] fill_wd;
  logic [SLOT_W-1:0] slot_cur, slot_base;
  logic [63:0] age_diff;

  always_comb begin
    if (bucket_count == 5'd0) n_eff = 5'd1;
    else if (int'(bucket_count) > NUM_BUCKETS) n_eff = 5'(NUM_BUCKETS);
    else n_eff = bucket_count;
  end

  // remainder of the key, one digit per cycle from the top
  always_comb begin
    rem_next = rem;
    for (int i = 0; i < DIGIT_W; i++) begin
      r6 = {rem_next, hsh[63 - i]};
      if (r6 >= {1'b0, n_eff}) r6 = r6 - {1'b0, n_eff};
      rem_next = r6[4:0];
    end
  end

  assign rd_pos  = (int'(rd) >= WAYS) ? '0 : rd;
  assign wpos    = ctrl.ins_head ? '0 : wr;
  assign rd_addr = AW'(int'(bkt) * WAYS + int'(rd_pos));
  assign wr_addr = AW'(int'(bkt) * WAYS + int'(wpos));
  assign slot_cur  = SLOT_W'(int'(bkt) * WAYS + int'(rd));
  assign slot_base = SLOT_W'(int'(bkt) * WAYS);
  assign age_diff  = stamp_r - time_q;

  assign ent_we  = ctrl.ins_shift | ctrl.ins_head | ctrl.cl_keep;
  assign wkey    = ctrl.ins_head ? key_r : key_q;
  assign wtime   = ctrl.ins_head ? stamp_r : time_q;
  assign fill_we = ctrl.ins_head | ctrl.cl_next_bkt | ctrl.clr_step;
  always_comb begin
    if (ctrl.ins_head) fill_wd = fill_q + FW'(1);
    else if (ctrl.cl_next_bkt) fill_wd = wr;
    else fill_wd = '0;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[wr_addr]  <= wkey;
      time_mem[wr_addr] <= wtime;
    end
    key_q  <= key_mem[rd_addr];
    time_q <= time_mem[rd_addr];
    if (fill_we) fill_mem[bkt] <= fill_wd;
    fill_q <= fill_mem[bkt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RST;
      age_limit    <= AGE_LIMIT_RST;
    end else if (wr_en) begin
      if (wr_index == REG_BUCKET_COUNT) bucket_count <= wr_data[4:0];
      else age_limit <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r   <= s_tuser;
      key_r   <= s_tdata[63:0];
      stamp_r <= s_tdata[127:64];
      hsh     <= s_tdata[63:0];
      rem     <= '0;
    end else if (ctrl.hash_step) begin
      hsh <= hsh << DIGIT_W;
      rem <= rem_next;
    end
    if (ctrl.cl_evict) pend_key <= key_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bkt    <= '0;
      hcnt   <= '0;
      rd     <= '0;
      wr     <= '0;
      cnt    <= '0;
      pend_v <= 1'b0;
    end else begin
      if (ctrl.load) begin
        bkt    <= '0;
        hcnt   <= '0;
        rd     <= '0;
        wr     <= '0;
        cnt    <= '0;
        pend_v <= 1'b0;
      end
      if (ctrl.hash_step) begin
        hcnt <= hcnt + 1'b1;
        if (stat.hash_done) begin
          bkt <= BW'(rem_next);
          rd  <= '0;
        end
      end
      if (ctrl.lk_next) rd <= rd + 1'b1;
      if (ctrl.ins_setup) begin
        rd <= fill_q - FW'(1);
        wr <= fill_q;
      end
      if (ctrl.ins_shift) begin
        rd <= rd - 1'b1;
        wr <= wr - 1'b1;
      end
      if (ctrl.cl_next_bkt || ctrl.clr_step) begin
        bkt <= stat.last_bkt ? '0 : bkt + 1'b1;
        rd  <= '0;
        wr  <= '0;
      end
      if (ctrl.cl_evict) begin
        pend_v <= 1'b1;
        cnt    <= cnt + 1'b1;
        rd     <= rd + 1'b1;
      end
      if (ctrl.cl_keep) begin
        wr <= wr + 1'b1;
        rd <= rd + 1'b1;
      end
    end
  end

  always_comb begin
    stat.in_cmd     = s_tuser;
    stat.cmd        = cmd_r;
    stat.hash_done  = (hcnt == HCNT_W'(HASH_STEPS - 1));
    stat.rd_ge_fill = (rd >= fill_q);
    stat.key_match  = (key_q == key_r);
    stat.fill_full  = (int'(fill_q) >= WAYS);
    stat.fill_zero  = (fill_q == '0);
    stat.rd_zero    = (rd == '0);
    stat.evict      = (int'(cnt) < MAX_EVICT) && (age_diff > {32'b0, age_limit});
    stat.pend_v     = pend_v;
    stat.last_bkt   = (bkt == BW'(NUM_BUCKETS - 1));
    stat.out_free   = !m_tvalid || m_tready;
  end

  logic              o_found, o_status, o_ev_v, o_last;
  logic [SLOT_W-1:0] o_slot;
  logic [63:0]       o_key;
  logic [COUNT_W-1:0] o_count;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (ctrl.emit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      o_found  <= 1'b0;
      o_slot   <= '0;
      o_status <= 1'b0;
      o_ev_v   <= 1'b0;
      o_key    <= '0;
      o_count  <= '0;
      o_last   <= 1'b1;
      case (ctrl.kind)
        R_LOOKUP: begin
          if (!stat.rd_ge_fill && stat.key_match) begin
            o_found <= 1'b1;
            o_slot  <= slot_cur;
          end
        end
        R_INS_OK: o_slot <= slot_base;
        R_FULL:   o_status <= 1'b1;
        R_EVICT: begin
          o_ev_v <= 1'b1;
          o_key  <= pend_key;
          o_last <= 1'b0;
        end
        R_FINAL: begin
          o_ev_v  <= pend_v;
          o_key   <= pend_v ? pend_key : '0;
          o_count <= cnt;
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {3'b000, o_count, o_key, o_slot};
  assign m_tuser = {o_ev_v, o_status, o_found};
  assign m_tlast = o_last;

endmodule
`default_nettype wire

// ----- src/hdt_ctrl.sv -----
`default_nettype none
module hdt_ctrl
  import hdt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  typedef enum logic [14:0] {
    S_CLR     = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_HASH    = 15'b000000000000100,
    S_LK_WAIT = 15'b000000000001000,
    S_LK_CMP  = 15'b000000000010000,
    S_IN_WAIT = 15'b000000000100000,
    S_IN_CHK  = 15'b000000001000000,
    S_IN_SRD  = 15'b000000010000000,
    S_IN_SWR  = 15'b000000100000000,
    S_IN_HEAD = 15'b000001000000000,
    S_IN_RES  = 15'b000010000000000,
    S_CL_WAIT = 15'b000100000000000,
    S_CL_CHK  = 15'b001000000000000,
    S_CL_FIN  = 15'b010000000000000,
    S_NULL    = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctrl = '0;
    ctrl.kind = R_NULL;
    case (state)
      S_CLR: begin
        ctrl.clr_step = 1'b1;
        if (stat.last_bkt) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          ctrl.load = 1'b1;
          case (stat.in_cmd)
            CMD_LOOKUP, CMD_INSERT: state_next = S_HASH;
            CMD_CLEAN: state_next = S_CL_WAIT;
            default: state_next = S_NULL;
          endcase
        end
      end
      S_HASH: begin
        ctrl.hash_step = 1'b1;
        if (stat.hash_done)
          state_next = (stat.cmd == CMD_INSERT) ? S_IN_WAIT : S_LK_WAIT;
      end
      S_LK_WAIT: state_next = S_LK_CMP;
      S_LK_CMP: begin
        if (stat.rd_ge_fill || stat.key_match) begin
          ctrl.kind = R_LOOKUP;
          if (stat.out_free) begin
            ctrl.emit = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          ctrl.lk_next = 1'b1;
          state_next = S_LK_WAIT;
        end
      end
      S_IN_WAIT: state_next = S_IN_CHK;
      S_IN_CHK: begin
        if (stat.fill_full) begin
          ctrl.kind = R_FULL;
          if (stat.out_free) begin
            ctrl.emit = 1'b1;
            state_next = S_IDLE;
          end
        end else if (stat.fill_zero) begin
          state_next = S_IN_HEAD;
        end else begin
          ctrl.ins_setup = 1'b1;
          state_next = S_IN_SRD;
        end
      end
      S_IN_SRD: state_next = S_IN_SWR;
      S_IN_SWR: begin
        ctrl.ins_shift = 1'b1;
        state_next = stat.rd_zero ? S_IN_HEAD : S_IN_SRD;
      end
      S_IN_HEAD: begin
        ctrl.ins_head = 1'b1;
        state_next = S_IN_RES;
      end
      S_IN_RES: begin
        ctrl.kind = R_INS_OK;
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CL_WAIT: state_next = S_CL_CHK;
      S_CL_CHK: begin
        if (stat.rd_ge_fill) begin
          ctrl.cl_next_bkt = 1'b1;
          state_next = stat.last_bkt ? S_CL_FIN : S_CL_WAIT;
        end else if (stat.evict) begin
          // the held eviction goes out once the next one is known
          ctrl.kind = R_EVICT;
          if (!stat.pend_v) begin
            ctrl.cl_evict = 1'b1;
            state_next = S_CL_WAIT;
          end else if (stat.out_free) begin
            ctrl.emit = 1'b1;
            ctrl.cl_evict = 1'b1;
            state_next = S_CL_WAIT;
          end
        end else begin
          ctrl.cl_keep = 1'b1;
          state_next = S_CL_WAIT;
        end
      end
      S_CL_FIN: begin
        ctrl.kind = R_FINAL;
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NULL: begin
        ctrl.kind = R_NULL;
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/hashed_device_table_with_aging_top.sv -----
`default_nettype none
// hashed device table with aging
// input stream: s_tuser carries the command (lookup, insert, clean sweep),
// s_tdata the key and the stamp. output stream: one beat per lookup, insert or unused
// command, one beat per evicted key on a sweep (or a single empty beat), m_tlast
// on the final beat of each command. configuration via wr_en / wr_index / wr_data.
// one command at a time; the bucket is found by a remainder unit taking one
// 4-bit digit of the key per cycle. a lookup then reads and compares one way
// at a time until a match or the bucket's fill; an insert moves each entry
// down one place, read then write, then writes the new key at the head. a
// sweep walks every physical bucket entry by entry, bound by the single read
// port of the entry memory. after reset a clearing pass zeroes the fill count
// of each bucket in turn; s_tready stays low during it. results sit in an
// output register: a stalled receiver holds the block at its next result, and a
// new command is taken once the previous one has put its last beat in that register.
module hashed_device_table_with_aging_top
  import hdt_pkg::*;
#(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS        = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic         wr_index,
  input  wire logic [31:0]  wr_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,  // key[63:0], stamp[127:64]
  input  wire logic [1:0]   s_tuser,  // cmd[1:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [79:0]       m_tdata,  // slot[5:0], evicted_key[69:6], evicted_count[76:70]
  output logic [2:0]        m_tuser,  // found[0], status[1], evicted_valid[2]
  output logic              m_tlast
);

  ctrl_t ctrl;
  stat_t stat;

  hdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  hdt_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  // clearing pass follows reset
  a_clr_after_rst: assert property (@(posedge clk) $past(rst) |-> !s_tready)
    else $error("input ready right after reset");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second command taken while one is at work");

  a_count_only_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[76:70] == 7'd0))
    else $error("eviction count on a beat that is not last");

  a_empty_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && !m_tuser[2]) |-> (m_tdata[76:70] == 7'd0))
    else $error("count without an evicted key");

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import hdt_pkg::*;

  localparam int NB = 16;
  localparam int NW = 4;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [63:0] stamp;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic        status;
    logic        ev_valid;
    logic [63:0] ev_key;
    logic [6:0]  ev_count;
    logic        last;
  } resp_t;

  logic clk = 0, rst = 1;
  logic wr_en = 0, wr_index = 0;
  logic [31:0] wr_data = 0;
  logic s_tvalid = 0, s_tready;
  logic [127:0] s_tdata = 0;
  logic [1:0] s_tuser = 0;
  logic m_tvalid, m_tready = 0, m_tlast;
  logic [79:0] m_tdata;
  logic [2:0] m_tuser;

  hashed_device_table_with_aging_top dut (.*);

  // shadow table
  logic [63:0] tbl_key [NB*NW];
  logic [63:0] tbl_time [NB*NW];
  int unsigned tbl_fill [NB];
  logic [4:0] cur_buckets;
  logic [31:0] cur_age;

  req_t pending_reqs[$];
  resp_t expected_resps[$];
  int errors = 0;
  longint unsigned cycles = 0;
  bit drive_gaps = 1, sink_gaps = 1, hold_input = 0;
  bit hold_req = 0;
  int hold_off = 0;

  function automatic int bucket_of(logic [63:0] k);
    int unsigned n;
    n = cur_buckets;
    if (n == 0) n = 1;
    if (n > NB) n = NB;
    return int'(k % n);
  endfunction

  function automatic resp_t mk(logic f, logic [5:0] s, logic st, logic ev,
                               logic [63:0] ek, logic [6:0] c, logic l);
    resp_t r;
    r.found = f; r.slot = s; r.status = st; r.ev_valid = ev;
    r.ev_key = ek; r.ev_count = c; r.last = l;
    return r;
  endfunction

  task automatic predict_table(req_t q);
    int b, p, rd, wr, cnt;
    bit hit;
    logic [63:0] k, t;
    case (q.cmd)
      CMD_LOOKUP: begin
        b = bucket_of(q.key);
        hit = 0;
        for (p = 0; p < tbl_fill[b] && !hit; p++)
          if (tbl_key[b*NW+p] == q.key) begin
            expected_resps.push_back(mk(1, 6'(b*NW+p), 0, 0, 0, 0, 1));
            hit = 1;
          end
        if (!hit) expected_resps.push_back(mk(0, 0, 0, 0, 0, 0, 1));
      end
      CMD_INSERT: begin
        b = bucket_of(q.key);
        if (tbl_fill[b] >= NW) expected_resps.push_back(mk(0, 0, 1, 0, 0, 0, 1));
        else begin
          for (p = tbl_fill[b]; p > 0; p--) begin
            tbl_key[b*NW+p] = tbl_key[b*NW+p-1];
            tbl_time[b*NW+p] = tbl_time[b*NW+p-1];
          end
          tbl_key[b*NW] = q.key;
          tbl_time[b*NW] = q.stamp;
          tbl_fill[b]++;
          expected_resps.push_back(mk(0, 6'(b*NW), 0, 0, 0, 0, 1));
        end
      end
      CMD_CLEAN: begin
        cnt = 0;
        for (b = 0; b < NB; b++) begin
          wr = 0;
          for (rd = 0; rd < tbl_fill[b]; rd++) begin
            k = tbl_key[b*NW+rd];
            t = tbl_time[b*NW+rd];
            if (cnt < MAX_EVICT && (q.stamp - t) > {32'd0, cur_age}) begin
              expected_resps.push_back(mk(0, 0, 0, 1, k, 0, 0));
              cnt++;
            end else begin
              tbl_key[b*NW+wr] = k;
              tbl_time[b*NW+wr] = t;
              wr++;
            end
          end
          tbl_fill[b] = wr;
        end
        if (cnt == 0) expected_resps.push_back(mk(0, 0, 0, 0, 0, 0, 1));
        else begin
          expected_resps[$].ev_count = 7'(cnt);
          expected_resps[$].last = 1;
        end
      end
      default: expected_resps.push_back(mk(0, 0, 0, 0, 0, 0, 1));
    endcase
  endtask

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  // driver: predicts at acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) predict_table({s_tuser, s_tdata[63:0], s_tdata[127:64]});
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && !hold_input &&
            !(drive_gaps && $urandom_range(0, 99) < 33)) begin
          req_t q;
          q = pending_reqs.pop_front();
          s_tvalid <= 1;
          s_tuser <= q.cmd;
          s_tdata <= {q.stamp, q.key};
        end else s_tvalid <= 0;
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (rst) hold_off <= 0;
    else if (hold_off > 0) hold_off <= hold_off - 1;
    else if (hold_req) hold_off <= 300;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        resp_t got, exp_r;
        got = mk(m_tuser[0], m_tdata[5:0], m_tuser[1], m_tuser[2], m_tdata[69:6],
                 m_tdata[76:70], m_tlast);
        if (expected_resps.size() == 0) begin
          $display("%0t unexpected beat %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp_r = expected_resps.pop_front();
          if (got !== exp_r) begin
            $display("%0t mismatch expected %h actual %h", $time, exp_r, got);
            errors <= errors + 1;
          end
        end
      end
      if (hold_off > 0) m_tready <= 0;
      else m_tready <= !(sink_gaps && $urandom_range(0, 99) < 33);
    end
  end

  task automatic add(logic [1:0] c, logic [63:0] k, logic [63:0] s);
    req_t q;
    q.cmd = c; q.key = k; q.stamp = s;
    pending_reqs.push_back(q);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    wr_en <= 1; wr_index <= idx; wr_data <= v;
    @(posedge clk);
    wr_en <= 0;
    if (idx == REG_BUCKET_COUNT) cur_buckets = v[4:0];
    else cur_age = v;
    @(posedge clk);
  endtask

  // keys drawn mostly from a small pool so lookups hit and buckets fill
  logic [63:0] key_pool [16];
  logic [63:0] now_ms;

  task automatic random_phase(int n);
    int i, r;
    logic [63:0] k;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(0, 15)];
      now_ms = now_ms + $urandom_range(0, 3000);
      if (r < 40) add(CMD_INSERT, k, now_ms);
      else if (r < 80) add(CMD_LOOKUP, k, {$urandom, $urandom});
      else if (r < 92) add(CMD_CLEAN, {$urandom, $urandom}, now_ms);
      else if (r < 96) add(CMD_SPARE, {$urandom, $urandom}, {$urandom, $urandom});
      else add(CMD_CLEAN, 0, {$urandom, $urandom});
    end
  endtask

  initial begin
    int i, ph;
    for (i = 0; i < NB; i++) tbl_fill[i] = 0;
    cur_buckets = BUCKET_COUNT_RST;
    cur_age = AGE_LIMIT_RST;
    for (i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_pool[1] = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: extremes, duplicates, full bucket, spare command, sweeps
    add(CMD_LOOKUP, 0, 0);
    add(CMD_CLEAN, 0, 0);
    for (i = 0; i < 5; i++) add(CMD_INSERT, 64'd16 * i, 64'd1000 + i);
    add(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    add(CMD_LOOKUP, 64'd32, 0);
    add(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    add(CMD_LOOKUP, 64'd5, 0);
    add(CMD_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add(CMD_CLEAN, 0, 64'd61003);
    add(CMD_CLEAN, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    add(CMD_LOOKUP, 64'd48, 0);
    drain();

    write_reg(REG_BUCKET_COUNT, 0);
    write_reg(REG_AGE_LIMIT, 32'hFFFF_FFFF);
    add(CMD_INSERT, 64'd7, 64'd0);
    add(CMD_INSERT, 64'd9, 64'd0);
    add(CMD_CLEAN, 0, 64'h1_0000_0000);
    add(CMD_CLEAN, 0, 64'hFFFF_FFFF);
    add(CMD_LOOKUP, 64'd7, 0);
    drain();

    now_ms = 0;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_BUCKET_COUNT, 31); write_reg(REG_AGE_LIMIT, 20000); end
        1: begin write_reg(REG_BUCKET_COUNT, 1); write_reg(REG_AGE_LIMIT, 0); end
        2: begin write_reg(REG_BUCKET_COUNT, $urandom_range(2, 15));
                 write_reg(REG_AGE_LIMIT, $urandom_range(1000, 30000)); end
        3: begin write_reg(REG_BUCKET_COUNT, 16); write_reg(REG_AGE_LIMIT, 60000); end
        4: begin write_reg(REG_BUCKET_COUNT, 17); write_reg(REG_AGE_LIMIT, 5000); end
        default: begin write_reg(REG_BUCKET_COUNT, 3); write_reg(REG_AGE_LIMIT, $urandom); end
      endcase
      drive_gaps = (ph != 3);
      sink_gaps = (ph != 3);
      random_phase(58);
      if (ph == 2) begin
        // stalled receiver while the sender keeps offering
        hold_req = 1;
        wait (hold_off > 0);
        hold_req = 0;
        wait (hold_off == 0);
      end
      if (ph == 4) begin
        // sender pauses until every result is in
        while (pending_reqs.size() > 30) @(posedge clk);
        hold_input = 1;
        while (s_tvalid || expected_resps.size() > 0) @(posedge clk);
        hold_input = 0;
      end
      drain();
    end

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
